>>> design/nga_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nga_pkg
// Shared sizes, operation and status codes, and the command and status
// structures that join the controller and the datapath of the graph table.
// ----------------------------------------------------------------------------
package nga_pkg;

    localparam int MAX_NODES = 16;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int ROW_W     = MAX_NODES;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_SET    = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_QUERY  = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_ABSENT  = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic             latch_in;
        logic             match;
        logic             decide;
        logic             sweep;
        logic [IDX_W-1:0] sweep_row;
        logic             load_out;
    } cmd_t;

    typedef struct packed {
        logic need_sweep;
        logic out_busy;
    } stat_t;

endpackage
`default_nettype wire

>>> design/nga_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nga_datapath
// Node name list, adjacency rows, node count, name match registers, result
// registers and the output register of the graph table.
// ----------------------------------------------------------------------------
module nga_datapath (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [15:0]   s_tdata,   // first_name, second_name
    input  wire logic [2:0]    s_tuser,   // operation
    input  wire nga_pkg::cmd_t cmd,
    output nga_pkg::stat_t     stat,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [15:0]        m_tdata    // status, edge_present, first_index, node_count
);

    localparam int N  = nga_pkg::MAX_NODES;
    localparam int IW = nga_pkg::IDX_W;
    localparam int CW = nga_pkg::CNT_W;
    localparam int RW = nga_pkg::ROW_W;

    logic [2:0]    op_reg;
    logic [7:0]    a_reg;
    logic [7:0]    b_reg;
    logic [7:0]    names_reg [N];
    logic [RW-1:0] rows_reg  [N];
    logic [CW-1:0] live_reg;
    logic [CW-1:0] live_next;
    logic [N-1:0]  match_a_reg;
    logic [N-1:0]  match_b_reg;
    logic [IW-1:0] pos_reg;
    logic [IW-1:0] pos_next;
    logic [1:0]    res_status_reg;
    logic [1:0]    res_status_next;
    logic          res_edge_reg;
    logic          res_edge_next;
    logic [IW-1:0] res_idx_reg;
    logic [IW-1:0] res_idx_next;
    logic          out_valid_reg;
    logic [15:0]   out_data_reg;

    logic          s_found;
    logic [IW-1:0] s_idx;
    logic          d_found;
    logic [IW-1:0] d_idx;
    logic          sweep_c;
    logic          name_wr_en;
    logic          row_wr_en;
    logic [RW-1:0] row_wr_data;
    logic [RW-1:0] sel_row;
    logic [RW-1:0] dest_bit;
    logic [RW-1:0] low_mask;
    logic [RW-1:0] col_bit;
    logic [RW-1:0] swept [N];
    logic [N-1:0]  match_a;
    logic [N-1:0]  match_b;
    logic [63:0]   idx_wide;
    logic [63:0]   cnt_wide;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            match_a[i] = (names_reg[i] == a_reg) && (CW'(i) < live_reg);
            match_b[i] = (names_reg[i] == b_reg) && (CW'(i) < live_reg);
        end
    end

    always_comb begin
        s_found = 1'b0;
        s_idx   = '0;
        d_found = 1'b0;
        d_idx   = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (match_a_reg[i]) begin
                s_found = 1'b1;
                s_idx   = IW'(i);
            end
            if (match_b_reg[i]) begin
                d_found = 1'b1;
                d_idx   = IW'(i);
            end
        end
    end

    assign sel_row  = rows_reg[s_idx];
    assign dest_bit = RW'(1) << d_idx;

    always_comb begin
        res_status_next = nga_pkg::ST_OK;
        res_edge_next   = 1'b0;
        res_idx_next    = '0;
        live_next       = live_reg;
        pos_next        = pos_reg;
        sweep_c         = 1'b0;
        name_wr_en      = 1'b0;
        row_wr_en       = 1'b0;
        row_wr_data     = sel_row;
        case (op_reg)
            nga_pkg::OP_INSERT: begin
                if (s_found) begin
                    res_status_next = nga_pkg::ST_PRESENT;
                    res_idx_next    = s_idx;
                end else if (live_reg >= CW'(N)) begin
                    res_status_next = nga_pkg::ST_FULL;
                end else begin
                    name_wr_en   = 1'b1;
                    res_idx_next = live_reg[IW-1:0];
                    live_next    = live_reg + CW'(1);
                    pos_next     = live_reg[IW-1:0];
                    sweep_c      = 1'b1;
                end
            end
            nga_pkg::OP_DELETE: begin
                if (!s_found) begin
                    res_status_next = nga_pkg::ST_ABSENT;
                end else begin
                    res_idx_next = s_idx;
                    live_next    = live_reg - CW'(1);
                    pos_next     = s_idx;
                    sweep_c      = 1'b1;
                end
            end
            nga_pkg::OP_SET, nga_pkg::OP_CLEAR, nga_pkg::OP_QUERY: begin
                if (!s_found || !d_found) begin
                    res_status_next = nga_pkg::ST_ABSENT;
                    res_idx_next    = s_found ? s_idx : '0;
                end else begin
                    res_idx_next = s_idx;
                    if (op_reg == nga_pkg::OP_SET) begin
                        row_wr_en   = 1'b1;
                        row_wr_data = sel_row | dest_bit;
                    end else if (op_reg == nga_pkg::OP_CLEAR) begin
                        row_wr_en   = 1'b1;
                        row_wr_data = sel_row & ~dest_bit;
                    end else begin
                        res_edge_next = |(sel_row & dest_bit);
                    end
                end
            end
            default: begin
                res_idx_next = s_found ? s_idx : '0;
            end
        endcase
    end

    assign low_mask = (RW'(1) << pos_reg) - RW'(1);
    assign col_bit  = RW'(1) << pos_reg;

    // Each row has its own update so that the sweep only reads fixed neighbors.
    for (genvar J = 0; J < N; J++) begin : g_row
        logic [RW-1:0] src;
        if (J < N - 1) begin : g_shift
            assign src = (IW'(J) >= pos_reg) ? rows_reg[J+1] : rows_reg[J];
        end else begin : g_top
            assign src = rows_reg[J];
        end
        always_comb begin
            if (op_reg == nga_pkg::OP_DELETE) begin
                if (CW'(J) >= live_reg) begin
                    swept[J] = '0;
                end else begin
                    swept[J] = (src & low_mask) | ((src >> 1) & ~low_mask);
                end
            end else begin
                if (IW'(J) == pos_reg) begin
                    swept[J] = '0;
                end else begin
                    swept[J] = rows_reg[J] & ~col_bit;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            op_reg <= s_tuser;
            a_reg  <= s_tdata[7:0];
            b_reg  <= s_tdata[15:8];
        end
        if (cmd.match) begin
            match_a_reg <= match_a;
            match_b_reg <= match_b;
        end
        if (cmd.decide) begin
            pos_reg        <= pos_next;
            res_status_reg <= res_status_next;
            res_edge_reg   <= res_edge_next;
            res_idx_reg    <= res_idx_next;
            if (name_wr_en) begin
                names_reg[live_reg[IW-1:0]] <= a_reg;
            end
        end
        if (cmd.sweep && (op_reg == nga_pkg::OP_DELETE)) begin
            for (int j = 0; j < N - 1; j++) begin
                if ((cmd.sweep_row == IW'(j)) && (IW'(j) >= pos_reg)) begin
                    names_reg[j] <= names_reg[j+1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg <= '0;
            for (int j = 0; j < N; j++) begin
                rows_reg[j] <= '0;
            end
        end else begin
            if (cmd.decide) begin
                live_reg <= live_next;
                if (row_wr_en) begin
                    rows_reg[s_idx] <= row_wr_data;
                end
            end
            if (cmd.sweep) begin
                for (int j = 0; j < N; j++) begin
                    if (cmd.sweep_row == IW'(j)) begin
                        rows_reg[j] <= swept[j];
                    end
                end
            end
        end
    end

    assign idx_wide = 64'(res_idx_reg);
    assign cnt_wide = 64'(live_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= {4'b0000, cnt_wide[4:0], idx_wide[3:0], res_edge_reg,
                             res_status_reg};
        end
    end

    assign stat.need_sweep = sweep_c;
    assign stat.out_busy   = out_valid_reg && !m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;

endmodule
`default_nettype wire

>>> design/nga_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nga_ctrl
// Sequencer of the graph table: takes a transaction, runs the name match,
// the decision, the row sweep when the node list changes, and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module nga_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire nga_pkg::stat_t stat,
    output nga_pkg::cmd_t       cmd
);

    localparam int IW = nga_pkg::IDX_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CMP   = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_SWEEP = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [IW-1:0] cnt_reg;
    logic [IW-1:0] cnt_next;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        s_tready      = 1'b0;
        cmd.latch_in  = 1'b0;
        cmd.match     = 1'b0;
        cmd.decide    = 1'b0;
        cmd.sweep     = 1'b0;
        cmd.sweep_row = cnt_reg;
        cmd.load_out  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_CMP;
                end
            end
            S_CMP: begin
                cmd.match  = 1'b1;
                state_next = S_DEC;
            end
            S_DEC: begin
                cmd.decide = 1'b1;
                cnt_next   = '0;
                state_next = stat.need_sweep ? S_SWEEP : S_DONE;
            end
            S_SWEEP: begin
                cmd.sweep = 1'b1;
                if (cnt_reg == IW'(nga_pkg::MAX_NODES - 1)) begin
                    state_next = S_DONE;
                end else begin
                    cnt_next = cnt_reg + IW'(1);
                end
            end
            S_DONE: begin
                if (!stat.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

>>> design/named_graph_adjacency_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// named_graph_adjacency_table
// Directed graph of named nodes with an adjacency bit matrix.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. An edge operation, a failed node
// operation or an unknown code passes from acceptance to the result in the
// output register through capture, name match over all live entries,
// decision with the edge read or write, and result load. A successful insert
// or delete adds a sweep over all MAX_NODES rows (16), one adjacency row per
// cycle, that shifts rows and names down or clears the new row and column.
// The next transaction is accepted as soon as the result is loaded, even
// while it still waits on m_tready.
module named_graph_adjacency_table (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // first_name [7:0], second_name [15:8]
    input  wire logic [2:0]  s_tuser,   // operation [2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // status [1:0], edge_present [2],
                                        // first_index [6:3], node_count [11:7]
);

    nga_pkg::cmd_t  cmd;
    nga_pkg::stat_t stat;

    nga_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    nga_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted again while a transaction is in progress");

    a_edge_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2]) |-> (m_tdata[1:0] == nga_pkg::ST_OK))
        else $error("edge reported with a failing status");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] == nga_pkg::ST_FULL))
            |-> (m_tdata[11:7] == 5'(nga_pkg::MAX_NODES)))
        else $error("table full reported below capacity");

    a_no_result_while_idle_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid)
        else $error("result appeared without a completed transaction");

endmodule
`default_nettype wire
